// File: rtl/core/pbd_pkg.sv
// Shared types and constants of the PackBits decoder core.
package pbd_pkg;

    localparam int BYTE_W      = 8;
    localparam int LANES       = 8;
    localparam int COUNT_W     = 4;
    localparam int STATUS_W    = 2;
    localparam int CAP_W       = 17;
    localparam int TOTAL_W     = 17;
    localparam int QUEUE_DEPTH = 4;
    localparam int TDATA_IN_W  = 8;
    localparam int TDATA_OUT_W = 88;

    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_LITERAL = 2'd1;
    localparam logic [1:0] PH_REPEAT  = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_TRUNC    = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_OVERFLOW = 2'd2;

    localparam logic [BYTE_W-1:0] NOOP_HEADER = 8'h80;
    localparam logic [CAP_W-1:0]  CAP_RESET   = 17'h10000;

    // One decoded run or event, queued between front and back.
    typedef struct packed {
        logic [BYTE_W-1:0]   value;
        logic [BYTE_W-1:0]   len;
        logic [STATUS_W-1:0] status;
        logic                eos;
    } t_job;

endpackage

// File: rtl/core/pbd_front.sv
// Front end: takes compressed bytes, tracks run state and issues decode jobs.
module pbd_front #(
    parameter int MAX_STRIP_BYTES = 65536,
    parameter int POS_W           = 17
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    input  logic [pbd_pkg::CAP_W-1:0]  i_cfg_data,
    input  logic                       i_accept,
    input  logic [pbd_pkg::BYTE_W-1:0] i_byte,
    input  logic                       i_last,
    output logic                       o_push,
    output pbd_pkg::t_job              o_job,
    output logic [POS_W-1:0]           o_base
);

    localparam int CW = (POS_W > pbd_pkg::CAP_W) ? POS_W : pbd_pkg::CAP_W;
    localparam logic [CW-1:0] MAX_CAP = CW'(MAX_STRIP_BYTES);

    logic [pbd_pkg::CAP_W-1:0]  r_cap;
    logic [1:0]                 r_phase, n_phase;
    logic [pbd_pkg::BYTE_W-1:0] r_lit_left, n_lit_left;
    logic [pbd_pkg::BYTE_W-1:0] r_rep_len, n_rep_len;
    logic [POS_W-1:0]           r_pos, n_pos;
    logic                       r_ignore, n_ignore;

    logic [CW-1:0]              cap_eff;
    logic [CW:0]                pos_x;
    logic [CW:0]                cap_x;
    logic [pbd_pkg::BYTE_W:0]   hdr_count;
    logic [CW:0]                rep_end;
    logic [pbd_pkg::BYTE_W-1:0] lit_dec;
    logic                       lit_done;
    logic                       finish;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= pbd_pkg::CAP_RESET;
        end else if (i_cfg_valid) begin
            r_cap <= i_cfg_data;
        end
    end

    always_comb begin
        cap_eff   = (MAX_CAP < CW'(r_cap)) ? MAX_CAP : CW'(r_cap);
        cap_x     = {1'b0, cap_eff};
        pos_x     = (CW + 1)'(r_pos);
        hdr_count = (i_byte < 8'd128) ? ({1'b0, i_byte} + 9'd1) : (9'd257 - {1'b0, i_byte});
        rep_end   = pos_x + (CW + 1)'(r_rep_len);
        lit_dec   = (r_lit_left != '0) ? (r_lit_left - 8'd1) : r_lit_left;
        lit_done  = (lit_dec == '0);
    end

    always_comb begin
        n_phase    = r_phase;
        n_lit_left = r_lit_left;
        n_rep_len  = r_rep_len;
        n_pos      = r_pos;
        n_ignore   = r_ignore;
        o_push     = 1'b0;
        o_job      = '{value: '0, len: '0, status: pbd_pkg::STAT_OK, eos: 1'b1};
        o_base     = r_pos;
        finish     = 1'b0;
        if (i_accept) begin
            if (r_ignore) begin
                finish = i_last;
            end else begin
                case (r_phase)
                    pbd_pkg::PH_LITERAL: begin
                        o_push       = 1'b1;
                        o_job.value  = i_byte;
                        o_job.len    = 8'd1;
                        n_pos        = r_pos + POS_W'(1);
                        n_lit_left   = lit_dec;
                        if (!lit_done && i_last) begin
                            o_job.status = pbd_pkg::STAT_TRUNC;
                            o_job.eos    = 1'b1;
                        end else begin
                            o_job.eos = lit_done && (i_last || (pos_x + 1'b1 >= cap_x));
                        end
                        if (lit_done) begin
                            n_phase = pbd_pkg::PH_HEADER;
                        end
                        finish = o_job.eos;
                    end
                    pbd_pkg::PH_REPEAT: begin
                        o_push      = 1'b1;
                        o_job.value = i_byte;
                        o_job.len   = r_rep_len;
                        o_job.eos   = i_last || (rep_end >= cap_x);
                        n_pos       = POS_W'(rep_end);
                        n_phase     = pbd_pkg::PH_HEADER;
                        n_rep_len   = '0;
                        finish      = o_job.eos;
                    end
                    default: begin
                        if (pos_x >= cap_x) begin
                            o_push = 1'b1;
                            finish = 1'b1;
                        end else if (i_byte == pbd_pkg::NOOP_HEADER) begin
                            o_push = i_last;
                            finish = i_last;
                        end else if (i_last) begin
                            o_push       = 1'b1;
                            o_job.status = pbd_pkg::STAT_TRUNC;
                            finish       = 1'b1;
                        end else if (pos_x + (CW + 1)'(hdr_count) > cap_x) begin
                            o_push       = 1'b1;
                            o_job.status = pbd_pkg::STAT_OVERFLOW;
                            finish       = 1'b1;
                        end else if (i_byte < 8'd128) begin
                            n_phase    = pbd_pkg::PH_LITERAL;
                            n_lit_left = hdr_count[pbd_pkg::BYTE_W-1:0];
                        end else begin
                            n_phase   = pbd_pkg::PH_REPEAT;
                            n_rep_len = hdr_count[pbd_pkg::BYTE_W-1:0];
                        end
                    end
                endcase
            end
            if (finish) begin
                if (i_last) begin
                    n_phase    = pbd_pkg::PH_HEADER;
                    n_lit_left = '0;
                    n_rep_len  = '0;
                    n_pos      = '0;
                    n_ignore   = 1'b0;
                end else begin
                    n_ignore = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= pbd_pkg::PH_HEADER;
            r_lit_left <= '0;
            r_rep_len  <= '0;
            r_pos      <= '0;
            r_ignore   <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_lit_left <= n_lit_left;
            r_rep_len  <= n_rep_len;
            r_pos      <= n_pos;
            r_ignore   <= n_ignore;
        end
    end

endmodule

// File: rtl/core/pbd_fifo.sv
// Small job queue between the front end and the back end.
module pbd_fifo #(
    parameter int WIDTH = 36
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_valid,
    output logic             o_full
);

    localparam int PTR_W = $clog2(pbd_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(pbd_pkg::QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] r_mem [pbd_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CNT_W'(pbd_pkg::QUEUE_DEPTH));
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: rtl/core/pbd_back.sv
// Back end: splits queued jobs into lane-wide results and holds the output register.
module pbd_back #(
    parameter int OUT_LANES = 8,
    parameter int POS_W     = 17
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_job_valid,
    input  pbd_pkg::t_job                   i_job,
    input  logic [POS_W-1:0]                i_base,
    output logic                            o_pop,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [pbd_pkg::BYTE_W-1:0]      o_lanes [pbd_pkg::LANES],
    output logic [pbd_pkg::COUNT_W-1:0]     o_count,
    output logic [pbd_pkg::STATUS_W-1:0]    o_status,
    output logic                            o_eos,
    output logic [pbd_pkg::TOTAL_W-1:0]     o_total
);

    localparam int LANES_EFF = (OUT_LANES < 1) ? 1 :
                               ((OUT_LANES > pbd_pkg::LANES) ? pbd_pkg::LANES : OUT_LANES);
    localparam logic [pbd_pkg::BYTE_W-1:0] CHUNK_MAX = pbd_pkg::BYTE_W'(LANES_EFF);

    logic                         r_busy;
    pbd_pkg::t_job                r_job;
    logic [pbd_pkg::BYTE_W-1:0]   r_left;
    logic [POS_W-1:0]             r_pos;
    logic                         r_out_valid;
    logic [pbd_pkg::BYTE_W-1:0]   r_lanes [pbd_pkg::LANES];
    logic [pbd_pkg::COUNT_W-1:0]  r_count;
    logic [pbd_pkg::STATUS_W-1:0] r_status;
    logic                         r_eos;
    logic [pbd_pkg::TOTAL_W-1:0]  r_total;

    logic [pbd_pkg::BYTE_W-1:0]   chunk;
    logic [pbd_pkg::BYTE_W-1:0]   left_next;
    logic [POS_W-1:0]             pos_next;
    logic                         advance;

    assign o_pop     = !r_busy && i_job_valid;
    assign advance   = r_busy && (!r_out_valid || i_ready);
    assign chunk     = (r_left < CHUNK_MAX) ? r_left : CHUNK_MAX;
    assign left_next = r_left - chunk;
    assign pos_next  = r_pos + POS_W'(chunk);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (advance && (left_next == '0)) begin
                r_busy <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job  <= i_job;
            r_left <= i_job.len;
            r_pos  <= i_base;
        end else if (advance) begin
            r_left <= left_next;
            r_pos  <= pos_next;
        end
        if (advance) begin
            for (int j = 0; j < pbd_pkg::LANES; j++) begin
                r_lanes[j] <= (pbd_pkg::BYTE_W'(j) < chunk) ? r_job.value : '0;
            end
            r_count  <= pbd_pkg::COUNT_W'(chunk);
            r_status <= r_job.status;
            r_eos    <= r_job.eos && (left_next == '0);
            r_total  <= pbd_pkg::TOTAL_W'(pos_next);
        end
    end

    assign o_valid  = r_out_valid;
    assign o_lanes  = r_lanes;
    assign o_count  = r_count;
    assign o_status = r_status;
    assign o_eos    = r_eos;
    assign o_total  = r_total;

endmodule

// File: rtl/core/packbits_rle_decoder_core.sv
// Top level of the PackBits strip decoder core.
// Compressed bytes enter one per item on the slave stream (tlast marks the last byte
// of a strip); decoded bytes leave as up to eight equal or single bytes per item on
// the master stream, with status in tuser and end of strip on tlast. A header byte
// yields no item unless it ends the strip; a literal byte gives one item; a repeat
// run gives one item per eight bytes, up to sixteen for a 128-byte run. The back-end
// splitter takes a new job from the queue only once it is done with the last one and
// then gives its items in turn while the output is free. A four-entry job queue lets
// input continue while a long run drains, so the input side stalls only when the
// queue fills. Capacity is written on the cfg channel and is taken as the smaller
// of it and MAX_STRIP_BYTES; write it only while idle.
module packbits_rle_decoder_core #(
    parameter int MAX_STRIP_BYTES = 65536,
    parameter int OUT_LANES       = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [pbd_pkg::CAP_W-1:0]       i_cfg_data,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [pbd_pkg::TDATA_IN_W-1:0]  i_s_tdata,   // [7:0] in_byte
    input  logic                            i_s_tlast,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [pbd_pkg::TDATA_OUT_W-1:0] o_m_tdata,   // lane0..lane7, lane_count, produced_total
    output logic [pbd_pkg::STATUS_W-1:0]    o_m_tuser,   // [1:0] status
    output logic                            o_m_tlast
);

    localparam int POS_W = $clog2(MAX_STRIP_BYTES + 1);
    localparam int Q_W   = $bits(pbd_pkg::t_job) + POS_W;

    logic                         accept;
    logic                         push;
    pbd_pkg::t_job                job_in;
    logic [POS_W-1:0]             base_in;
    logic [Q_W-1:0]               q_out;
    logic                         q_valid;
    logic                         q_full;
    logic                         pop;
    pbd_pkg::t_job                job_out;
    logic [POS_W-1:0]             base_out;
    logic [pbd_pkg::BYTE_W-1:0]   lanes [pbd_pkg::LANES];
    logic [pbd_pkg::COUNT_W-1:0]  lane_count;
    logic [pbd_pkg::TOTAL_W-1:0]  total;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = !q_full;
    assign accept      = i_s_tvalid && o_s_tready;

    pbd_front #(
        .MAX_STRIP_BYTES (MAX_STRIP_BYTES),
        .POS_W           (POS_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_byte      (i_s_tdata[pbd_pkg::BYTE_W-1:0]),
        .i_last      (i_s_tlast),
        .o_push      (push),
        .o_job       (job_in),
        .o_base      (base_in)
    );

    pbd_fifo #(
        .WIDTH (Q_W)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({base_in, job_in}),
        .i_pop   (pop),
        .o_data  (q_out),
        .o_valid (q_valid),
        .o_full  (q_full)
    );

    assign job_out  = q_out[$bits(pbd_pkg::t_job)-1:0];
    assign base_out = q_out[Q_W-1:$bits(pbd_pkg::t_job)];

    pbd_back #(
        .OUT_LANES (OUT_LANES),
        .POS_W     (POS_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (job_out),
        .i_base      (base_out),
        .o_pop       (pop),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_lanes     (lanes),
        .o_count     (lane_count),
        .o_status    (o_m_tuser),
        .o_eos       (o_m_tlast),
        .o_total     (total)
    );

    assign o_m_tdata = {3'b000, total, lane_count,
                        lanes[7], lanes[6], lanes[5], lanes[4],
                        lanes[3], lanes[2], lanes[1], lanes[0]};

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// Testbench for the PackBits strip decoder core: directed strips and random streams checked per item.
module tb_top;

    localparam int MAX_STRIP  = 65536;
    localparam int HOLD_LEN   = 400;
    localparam int SETTLE_LEN = 40;

    typedef struct {
        logic [pbd_pkg::BYTE_W-1:0]   value;
        logic [pbd_pkg::COUNT_W-1:0]  count;
        logic [pbd_pkg::STATUS_W-1:0] status;
        logic                         eos;
        logic [pbd_pkg::TOTAL_W-1:0]  total;
    } t_decoded;

    logic                            i_clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_valid = 1'b0;
    logic [pbd_pkg::CAP_W-1:0]       cfg_data = '0;
    logic                            s_tvalid = 1'b0;
    logic [pbd_pkg::TDATA_IN_W-1:0]  s_tdata = '0;
    logic                            s_tlast = 1'b0;
    logic                            m_tready = 1'b0;
    logic                            o_cfg_ready;
    logic                            o_s_tready;
    logic                            o_m_tvalid;
    logic [pbd_pkg::TDATA_OUT_W-1:0] o_m_tdata;
    logic [pbd_pkg::STATUS_W-1:0]    o_m_tuser;
    logic                            o_m_tlast;

    t_decoded    decoded_q [$];
    int          fails = 0;
    int          fed = 0;
    bit          quiet = 1'b0;
    bit          hold_req = 1'b0;

    // predictor state
    logic [1:0]  dec_phase = pbd_pkg::PH_HEADER;
    int          lit_left = 0;
    int          rep_len = 0;
    int          out_pos = 0;
    bit          skip_rest = 1'b0;
    int          cap_reg = pbd_pkg::CAP_RESET;

    packbits_rle_decoder_core #(
        .MAX_STRIP_BYTES(MAX_STRIP),
        .OUT_LANES(pbd_pkg::LANES)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(rst_n),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data(cfg_data),
        .i_s_tvalid(s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata(s_tdata),
        .i_s_tlast(s_tlast),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(m_tready),
        .o_m_tdata(o_m_tdata),
        .o_m_tuser(o_m_tuser),
        .o_m_tlast(o_m_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("FAIL packbits_rle_decoder_core");
        $finish;
    end

    task automatic clear_strip();
        dec_phase = pbd_pkg::PH_HEADER;
        lit_left  = 0;
        rep_len   = 0;
        out_pos   = 0;
        skip_rest = 1'b0;
    endtask

    task automatic end_strip(input logic last);
        if (last) begin
            clear_strip();
        end else begin
            skip_rest = 1'b1;
        end
    endtask

    task automatic push_decoded(input logic [7:0] value, input int count,
                                input logic [1:0] status, input logic eos);
        t_decoded d;
        d.value  = (count > 0) ? value : 8'h00;
        d.count  = pbd_pkg::COUNT_W'(count);
        d.status = status;
        d.eos    = eos;
        d.total  = pbd_pkg::TOTAL_W'(out_pos);
        decoded_q.push_back(d);
    endtask

    // Expected items for one accepted compressed byte.
    task automatic decode_byte(input logic [7:0] b, input logic last);
        int          budget;
        int          run_len;
        int          left;
        int          chunk;
        int          n;
        logic [1:0]  status;
        logic        eos;
        bit          done;
        budget  = (cap_reg > MAX_STRIP) ? MAX_STRIP : cap_reg;
        if (skip_rest) begin
            if (last) clear_strip();
            return;
        end
        if (dec_phase == pbd_pkg::PH_LITERAL) begin
            status = pbd_pkg::STAT_OK;
            eos    = 1'b0;
            out_pos++;
            if (lit_left > 0) lit_left--;
            done = (lit_left == 0);
            if (!done && last) begin
                status = pbd_pkg::STAT_TRUNC;
                eos    = 1'b1;
            end else if (done && (last || out_pos >= budget)) begin
                eos = 1'b1;
            end
            push_decoded(b, 1, status, eos);
            if (done) dec_phase = pbd_pkg::PH_HEADER;
            if (eos) end_strip(last);
            return;
        end
        if (dec_phase == pbd_pkg::PH_REPEAT) begin
            left      = rep_len;
            dec_phase = pbd_pkg::PH_HEADER;
            rep_len   = 0;
            n         = 0;
            while (left > 0) begin
                chunk   = (left < pbd_pkg::LANES) ? left : pbd_pkg::LANES;
                left   -= chunk;
                out_pos += chunk;
                push_decoded(b, chunk, pbd_pkg::STAT_OK,
                             (left == 0) && (last || out_pos >= budget));
                n++;
            end
            if (n > 0 && (last || out_pos >= budget)) end_strip(last);
            return;
        end
        if (out_pos >= budget) begin
            push_decoded(8'h00, 0, pbd_pkg::STAT_OK, 1'b1);
            end_strip(last);
            return;
        end
        if (b == pbd_pkg::NOOP_HEADER) begin
            if (last) begin
                push_decoded(8'h00, 0, pbd_pkg::STAT_OK, 1'b1);
                end_strip(last);
            end
            return;
        end
        run_len = (b < 8'd128) ? int'(b) + 1 : 257 - int'(b);
        if (last) begin
            push_decoded(8'h00, 0, pbd_pkg::STAT_TRUNC, 1'b1);
            end_strip(last);
        end else if (out_pos + run_len > budget) begin
            push_decoded(8'h00, 0, pbd_pkg::STAT_OVERFLOW, 1'b1);
            end_strip(last);
        end else if (b < 8'd128) begin
            dec_phase = pbd_pkg::PH_LITERAL;
            lit_left  = run_len;
        end else begin
            dec_phase = pbd_pkg::PH_REPEAT;
            rep_len   = run_len;
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        if (!quiet && $urandom_range(99) < 38) begin
            s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 38);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge i_clk); while (!o_s_tready);
        decode_byte(b, last);
        fed++;
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_LEN) @(posedge i_clk);
    endtask

    task automatic write_capacity(input int value);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= pbd_pkg::CAP_W'(value);
        do @(posedge i_clk); while (!o_cfg_ready);
        cap_reg = value;
        cfg_valid <= 1'b0;
    endtask

    task automatic send_strip();
        logic [7:0] seq [$];
        int         shape;
        int         runs;
        int         len;
        int         r;
        shape = $urandom_range(99);
        if (shape < 10) begin
            len = $urandom_range(1, 8);
            repeat (len) seq.push_back(8'($urandom));
        end else begin
            runs = $urandom_range(1, 6);
            repeat (runs) begin
                r = $urandom_range(99);
                if (r < 45) begin
                    len = ($urandom_range(9) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 8);
                    seq.push_back(8'(len - 1));
                    repeat (len) seq.push_back(8'($urandom));
                end else if (r < 88) begin
                    len = $urandom_range(2, 128);
                    seq.push_back(8'(257 - len));
                    seq.push_back(8'($urandom));
                end else begin
                    seq.push_back(pbd_pkg::NOOP_HEADER);
                end
            end
            // may be cut short: a truncated strip
            if (shape < 28) seq = seq[0:$urandom_range(seq.size() - 1)];
        end
        foreach (seq[i]) send_byte(seq[i], i == seq.size() - 1);
    endtask

    task automatic test_reset_budget();
        send_byte(8'h81, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(pbd_pkg::NOOP_HEADER, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hA5, 1'b1);
    endtask

    task automatic test_strip_edges();
        send_byte(pbd_pkg::NOOP_HEADER, 1'b1);
        send_byte(8'h05, 1'b1);
        send_byte(8'hFE, 1'b1);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h11, 1'b0);
        send_byte(8'h22, 1'b1);
    endtask

    task automatic test_small_budget();
        write_capacity(4);
        send_byte(8'h04, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h02, 1'b1);
        send_byte(8'hFD, 1'b0);
        send_byte(8'h7E, 1'b0);
        send_byte(8'h00, 1'b1);
    endtask

    task automatic test_zero_budget();
        write_capacity(0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h12, 1'b1);
        send_byte(pbd_pkg::NOOP_HEADER, 1'b1);
    endtask

    task automatic test_random_strips(input int budget, input int target);
        int goal;
        write_capacity(budget);
        goal = fed + target;
        while (fed < goal) send_strip();
    endtask

    task automatic test_backpressure();
        write_capacity(MAX_STRIP);
        quiet    = 1'b1;
        hold_req = 1'b1;
        for (int i = 0; i < 10; i++) begin
            send_byte(8'h81, 1'b0);
            send_byte(8'($urandom), i == 9);
        end
        quiet = 1'b0;
    endtask

    task automatic test_steady_stream();
        quiet = 1'b1;
        test_random_strips(MAX_STRIP, 100);
        quiet = 1'b0;
    endtask

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endtask

    task automatic check_item(input logic [pbd_pkg::TDATA_OUT_W-1:0] d,
                              input logic [pbd_pkg::STATUS_W-1:0] st, input logic eos);
        t_decoded want;
        if (decoded_q.size() == 0) begin
            $error("item with none expected: tdata=%h tuser=%0d tlast=%0b", d, st, eos);
            fails++;
            return;
        end
        want = decoded_q.pop_front();
        for (int i = 0; i < pbd_pkg::LANES; i++) begin
            compare_field($sformatf("lane%0d", i), (i < want.count) ? want.value : 0,
                          d[i*pbd_pkg::BYTE_W +: pbd_pkg::BYTE_W]);
        end
        compare_field("lane_count", want.count,
                      d[pbd_pkg::LANES*pbd_pkg::BYTE_W +: pbd_pkg::COUNT_W]);
        compare_field("produced_total", want.total,
                      d[pbd_pkg::LANES*pbd_pkg::BYTE_W+pbd_pkg::COUNT_W +: pbd_pkg::TOTAL_W]);
        compare_field("status", want.status, st);
        compare_field("end_of_strip", want.eos, eos);
    endtask

    initial begin
        logic [pbd_pkg::TDATA_OUT_W-1:0] got_data;
        logic [pbd_pkg::STATUS_W-1:0]    got_user;
        logic                            got_last;
        forever begin
            @(posedge i_clk);
            if (rst_n && o_m_tvalid && m_tready) begin
                got_data = o_m_tdata;
                got_user = o_m_tuser;
                got_last = o_m_tlast;
                @(negedge i_clk);
                check_item(got_data, got_user, got_last);
            end
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_LEN) @(posedge i_clk);
            end
            m_tready <= quiet || ($urandom_range(99) >= 38);
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_budget();
        test_strip_edges();
        test_small_budget();
        test_zero_budget();
        test_random_strips(MAX_STRIP, 200);
        test_backpressure();
        test_random_strips($urandom_range(16, 300), 150);
        test_random_strips($urandom_range(0, 8), 60);
        test_steady_stream();
        settle();
        if (fails == 0 && decoded_q.size() == 0) begin
            $display("PASS packbits_rle_decoder_core");
        end else begin
            $display("FAIL packbits_rle_decoder_core");
        end
        $finish;
    end

endmodule
